[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the page allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define RPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define RPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

[rtl/rpa_pkg.sv]
// Types and constants shared by the page allocator files.
`default_nettype none
package rpa_pkg;

    localparam int ADDR_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 3;
    localparam int CNT_OUT_W = 8;
    localparam int CFG_IDX_W = 8;

    localparam logic [CMD_W-1:0] CMD_INIT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INC   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_OOM      = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR = 3'd2;
    localparam logic [STAT_W-1:0] ST_DBL_FREE = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_REF  = 3'd4;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END  = 8'd1;

    localparam logic [ADDR_W-1:0] REGION_BASE_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] KERNEL_END_RST  = 32'h8002_0000;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
    } rpa_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [ADDR_W-1:0]    page_address;
        logic [CNT_OUT_W-1:0] ref_count;
        logic                 page_released;
    } rpa_res_t;

    typedef struct packed {
        logic in_range;
        logic aligned;
        logic below_kernel;
        logic init_empty;
    } rpa_chk_t;

endpackage
`default_nettype wire

[rtl/rpa_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/rpa_addr_check.sv]
// Region limits, page index and init range derived from the address and configuration.
`default_nettype none
module rpa_addr_check
    import rpa_pkg::*;
#(
    parameter int NUM_PAGES = 32768,
    parameter int PAGE_BITS = 12
) (
    input  wire logic [ADDR_W-1:0]              region_base,
    input  wire logic [ADDR_W-1:0]              kernel_end,
    input  wire logic [ADDR_W-1:0]              address,
    output rpa_chk_t                            chk,
    output logic      [$clog2(NUM_PAGES)-1:0]   page_idx,
    output logic      [$clog2(NUM_PAGES)-1:0]   init_first,
    output logic      [$clog2(NUM_PAGES):0]     page_limit
);

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam logic [63:0] SPAN = 64'(NUM_PAGES) << PAGE_BITS;
    localparam logic [33:0] LIMIT34 = 34'h1_0000_0000;
    localparam logic [33:0] SPAN34 = (SPAN >= 64'h1_0000_0000) ? LIMIT34 : 34'(SPAN);
    localparam logic [ADDR_W-1:0] PG_MASK = 32'((64'd1 << PAGE_BITS) - 64'd1);
    localparam logic [33:0] PG_MASK34 = {2'b00, PG_MASK};

    logic [ADDR_W-1:0] base32;
    logic [ADDR_W-1:0] offset;
    logic [33:0]       base34;
    logic [33:0]       sum34;
    logic [33:0]       top34;
    logic [33:0]       addr34;
    logic [33:0]       kend34;
    logic [33:0]       start34;

    always_comb
    begin
        base32  = region_base & ~PG_MASK;
        base34  = {2'b00, base32};
        sum34   = base34 + SPAN34;
        top34   = (sum34 > LIMIT34) ? LIMIT34 : sum34;
        addr34  = {2'b00, address};
        offset  = address - base32;
        kend34  = ({2'b00, kernel_end} + PG_MASK34) & ~PG_MASK34;
        start34 = (kend34 < base34) ? base34 : kend34;

        chk.in_range     = (addr34 >= base34) && (addr34 < top34);
        chk.aligned      = (address & PG_MASK) == '0;
        chk.below_kernel = address < kernel_end;
        chk.init_empty   = start34 >= top34;

        page_idx   = IDX_W'(offset >> PAGE_BITS);
        init_first = IDX_W'((start34 - base34) >> PAGE_BITS);
        page_limit = (IDX_W + 1)'((top34 - base34) >> PAGE_BITS);
    end

endmodule
`default_nettype wire

[rtl/refcounted_page_allocator_core.sv]
// Top level of the reference-counted page allocator: command sequencer around two RAMs.
// Sequence: an accepted command enters DECODE; alloc then goes through POP, and free,
// inc and query through UPDATE, before done. Bad addresses, out of memory, unknown
// commands and an empty init end in DECODE; an init that frees pages walks them in
// INIT. The receiver cannot stall; a new command is taken in the cycle its predecessor's
// result is shown. After reset a clearing pass zeroes the count RAM with busy high.
`default_nettype none
module refcounted_page_allocator_core
    import rpa_pkg::*;
#(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BITS  = 12,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire rpa_cmd_t             cmd,
    output logic                      done,
    output rpa_res_t                  result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int FC_W  = $clog2(NUM_PAGES + 1);
    localparam int EXT_W = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [ADDR_W-1:0] PG_MASK = 32'((64'd1 << PAGE_BITS) - 64'd1);
    localparam logic [IDX_W-1:0] LAST_PAGE = IDX_W'(NUM_PAGES - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_POP    = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_INIT   = 3'd5;

    function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [COUNT_BITS-1:0] c);
        logic [EXT_W-1:0] e;
        e = EXT_W'(c);
        return e[CNT_OUT_W-1:0];
    endfunction

    logic [2:0]            state_reg, state_next;
    rpa_cmd_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      walk_reg, walk_next;
    logic [IDX_W-1:0]      last_reg, last_next;
    logic [FC_W-1:0]       fc_reg, fc_next;
    logic [ADDR_W-1:0]     base_reg;
    logic [ADDR_W-1:0]     kend_reg;
    rpa_res_t              res_reg, res_next;
    logic                  done_reg, done_next;

    rpa_chk_t              chk;
    logic [IDX_W-1:0]      page_idx;
    logic [IDX_W-1:0]      init_first;
    logic [IDX_W:0]        page_limit;

    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [IDX_W-1:0]      cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic                  stk_we;
    logic [IDX_W-1:0]      stk_waddr;
    logic [IDX_W-1:0]      stk_wdata;
    logic [IDX_W-1:0]      stk_raddr;
    logic [IDX_W-1:0]      stk_rdata;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [ADDR_W-1:0]     base32;

    rpa_addr_check #(
        .NUM_PAGES (NUM_PAGES),
        .PAGE_BITS (PAGE_BITS)
    ) u_addr_check (
        .region_base (base_reg),
        .kernel_end  (kend_reg),
        .address     (cmd_reg.address),
        .chk         (chk),
        .page_idx    (page_idx),
        .init_first  (init_first),
        .page_limit  (page_limit)
    );

    rpa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    rpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign busy      = state_reg != S_IDLE;
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;
    assign cnt_raddr = page_idx;
    assign stk_raddr = IDX_W'(fc_reg - FC_W'(1));
    assign base32    = base_reg & ~PG_MASK;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        walk_next  = walk_reg;
        last_next  = last_reg;
        fc_next    = fc_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        cnt_we     = 1'b0;
        cnt_waddr  = walk_reg;
        cnt_wdata  = '0;
        stk_we     = 1'b0;
        stk_waddr  = IDX_W'(fc_reg);
        stk_wdata  = walk_reg;
        cnt_new    = '0;

        case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                walk_next = walk_reg + IDX_W'(1);
                if (walk_reg == LAST_PAGE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_next   = '0;
                idx_next   = page_idx;
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (cmd_reg.command)
                    CMD_INIT:
                    begin
                        fc_next = '0;
                        if (!chk.init_empty)
                        begin
                            walk_next  = init_first;
                            last_next  = IDX_W'(page_limit - (IDX_W + 1)'(1));
                            state_next = S_INIT;
                            done_next  = 1'b0;
                        end
                    end
                    CMD_ALLOC:
                    begin
                        if (fc_reg == '0)
                        begin
                            res_next.status = ST_OOM;
                        end
                        else
                        begin
                            fc_next    = fc_reg - FC_W'(1);
                            state_next = S_POP;
                            done_next  = 1'b0;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (!chk.aligned || chk.below_kernel || !chk.in_range)
                        begin
                            res_next.status = ST_BAD_ADDR;
                        end
                        else
                        begin
                            state_next = S_UPDATE;
                            done_next  = 1'b0;
                        end
                    end
                    CMD_INC, CMD_QUERY:
                    begin
                        if (!chk.in_range)
                        begin
                            res_next.status = ST_BAD_ADDR;
                        end
                        else
                        begin
                            state_next = S_UPDATE;
                            done_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            S_POP:
            begin
                cnt_we                = 1'b1;
                cnt_waddr             = stk_rdata;
                cnt_wdata             = COUNT_BITS'(1);
                res_next              = '0;
                res_next.page_address = base32 + 32'({32'b0, stk_rdata} << PAGE_BITS);
                res_next.ref_count    = cnt_out(COUNT_BITS'(1));
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end
            S_UPDATE:
            begin
                cnt_waddr  = idx_reg;
                stk_wdata  = idx_reg;
                res_next   = '0;
                done_next  = 1'b1;
                state_next = S_IDLE;
                case (cmd_reg.command)
                    CMD_FREE:
                    begin
                        if (cnt_rdata == '0)
                        begin
                            res_next.status = ST_DBL_FREE;
                        end
                        else
                        begin
                            cnt_new            = cnt_rdata - COUNT_BITS'(1);
                            cnt_we             = 1'b1;
                            cnt_wdata          = cnt_new;
                            res_next.ref_count = cnt_out(cnt_new);
                            if (cnt_new == '0)
                            begin
                                res_next.page_released = 1'b1;
                                if (fc_reg < FC_W'(NUM_PAGES))
                                begin
                                    stk_we  = 1'b1;
                                    fc_next = fc_reg + FC_W'(1);
                                end
                            end
                        end
                    end
                    CMD_INC:
                    begin
                        if (cnt_rdata == '0)
                        begin
                            res_next.status = ST_NOT_REF;
                        end
                        else if (cnt_rdata == COUNT_MAX)
                        begin
                            res_next.status    = ST_OVERFLOW;
                            res_next.ref_count = cnt_out(cnt_rdata);
                        end
                        else
                        begin
                            cnt_new            = cnt_rdata + COUNT_BITS'(1);
                            cnt_we             = 1'b1;
                            cnt_wdata          = cnt_new;
                            res_next.ref_count = cnt_out(cnt_new);
                        end
                    end
                    default:
                    begin
                        res_next.ref_count = cnt_out(cnt_rdata);
                    end
                endcase
            end
            S_INIT:
            begin
                cnt_we    = 1'b1;
                stk_we    = 1'b1;
                fc_next   = fc_reg + FC_W'(1);
                walk_next = walk_reg + IDX_W'(1);
                if (walk_reg == last_reg)
                begin
                    res_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            walk_reg  <= '0;
            fc_reg    <= '0;
            done_reg  <= 1'b0;
            base_reg  <= REGION_BASE_RST;
            kend_reg  <= KERNEL_END_RST;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            fc_reg    <= fc_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_REGION_BASE: base_reg <= cfg_data;
                    CFG_KERNEL_END:  kend_reg <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
        res_reg  <= res_next;
    end

endmodule
`default_nettype wire

[rtl/rpa_checker.sv]
// Port-level assertions for the page allocator and their binding to the top level.
`default_nettype none
`include "assert_macros.svh"
module rpa_checker
    import rpa_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     done,
    input wire rpa_res_t result
);

    `RPA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `RPA_ASSERT_NXT(a_done_single, done, !done)
    `RPA_ASSERT_IMP(a_error_clean, done && (result.status != ST_OK), (result.page_address == '0) && !result.page_released)
    `RPA_ASSERT_IMP(a_release_zero, done && result.page_released, (result.ref_count == '0) && (result.status == ST_OK))

endmodule

bind refcounted_page_allocator_core rpa_checker u_rpa_checker (.*);
`default_nettype wire
